// File: rtl/lcdfe_pkg.sv
// ----------------------------------------------------------------------------
// lcdfe_pkg
// Shared types and byte codes for the LCD command frame encoder.
// ----------------------------------------------------------------------------
package lcdfe_pkg;

  localparam int FrameBytes = 11;
  localparam int CountW     = $clog2(FrameBytes + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_GOTO      = 3'd1,
    OP_TEXT      = 3'd2,
    OP_DEFCHAR   = 3'd3,
    OP_CONTRAST  = 3'd4,
    OP_BACKLIGHT = 3'd5,
    OP_GPO       = 3'd6
  } op_t;

  localparam logic [1:0] ProtoBasic = 2'd1;
  localparam logic [1:0] ProtoExt   = 2'd2;

  localparam logic [7:0] ByteEsc     = 8'hFE;
  localparam logic [7:0] ByteFormFd  = 8'h0C;
  localparam logic [7:0] CmdClear    = 8'h58;
  localparam logic [7:0] CmdGoto     = 8'h47;
  localparam logic [7:0] CmdDefChar  = 8'h4E;
  localparam logic [7:0] CmdContrast = 8'h50;
  localparam logic [7:0] CmdBlOn     = 8'h42;
  localparam logic [7:0] CmdBlOff    = 8'h46;
  localparam logic [7:0] CmdGpoOn    = 8'h57;
  localparam logic [7:0] CmdGpoOff   = 8'h56;
  localparam logic [7:0] CmdGpoPwm   = 8'hC0;
  localparam logic [7:0] LevelFull   = 8'd255;

  // One classified request: the bytes of its frame, ready to shift out.
  typedef struct packed {
    logic [FrameBytes-1:0][7:0] bytes;
    logic [CountW-1:0]          count;       // 1..FrameBytes
    logic                       byte_valid;  // 0 for an answer-only result
    logic [7:0]                 level;
  } frame_t;

endpackage

// File: rtl/lcd_command_frame_encoder.sv
// ----------------------------------------------------------------------------
// lcd_command_frame_encoder
// Encodes display commands into serial byte frames, last byte marked.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | operation row column text_byte char_code
//          |                     | pattern value gpo_index
//  out     | out_valid/out_stall | out_byte byte_valid last level
//  cfg     | cfg_we              | cfg_wdata (protocol)
//
//  A frame of n bytes (1..11) leaves one byte per cycle while out_stall is low,
//  from the back serializer; that serializer sets the sustained rate.
//  A request is taken every cycle while the two-entry frame queue has room.
//  First byte reaches out_valid through the queue entry, then the output register.
//  Reset: protocol 1, contrast and backlight 0, queue and output empty.
//  out_stall holds the output register; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module lcd_command_frame_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [7:0]         row,
  input  logic [7:0]         column,
  input  logic [7:0]         text_byte,
  input  logic [7:0]         char_code,
  input  logic [63:0]        pattern,
  input  logic signed [15:0] value,
  input  logic [2:0]         gpo_index,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [7:0]         level
);

  lcdfe_pkg::frame_t push_frame;
  lcdfe_pkg::frame_t head;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;

  lcdfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .row       (row),
    .column    (column),
    .text_byte (text_byte),
    .char_code (char_code),
    .pattern   (pattern),
    .value     (value),
    .gpo_index (gpo_index),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .frame     (push_frame)
  );

  lcdfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  lcdfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .level      (level)
  );

endmodule

// File: rtl/lcdfe_front.sv
// ----------------------------------------------------------------------------
// lcdfe_front
// Accepts requests, keeps protocol and levels, and builds the byte frame.
// ----------------------------------------------------------------------------
module lcdfe_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            operation,
  input  logic [7:0]            row,
  input  logic [7:0]            column,
  input  logic [7:0]            text_byte,
  input  logic [7:0]            char_code,
  input  logic [63:0]           pattern,
  input  logic signed [15:0]    value,
  input  logic [2:0]            gpo_index,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  q_full,
  output logic                  push,
  output lcdfe_pkg::frame_t     frame
);

  logic [1:0] protocol;
  logic [7:0] contrast_level;
  logic [7:0] backlight_level;
  logic [7:0] contrast_next;
  logic [7:0] backlight_next;
  logic       accept;
  logic       has_frame;
  logic       is_query;
  logic       val_neg;
  logic       val_zero;
  logic [7:0] clamped;
  logic [7:0] gpo_num;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && has_frame;

  assign val_neg  = value[15];
  assign val_zero = (value == 16'sd0);
  assign is_query = (value == -16'sd1);
  assign gpo_num  = {5'd0, gpo_index} + 8'd1;

  always_comb begin
    if (val_neg) begin
      clamped = 8'd0;
    end else if (value[14:8] != 7'd0) begin
      clamped = lcdfe_pkg::LevelFull;
    end else begin
      clamped = value[7:0];
    end
  end

  always_comb begin
    frame          = '0;
    frame.byte_valid = 1'b1;
    has_frame      = 1'b1;
    contrast_next  = contrast_level;
    backlight_next = backlight_level;
    case (lcdfe_pkg::op_t'(operation))
      lcdfe_pkg::OP_CLEAR: begin
        if (protocol == lcdfe_pkg::ProtoBasic) begin
          frame.bytes[0] = lcdfe_pkg::ByteFormFd;
          frame.count    = lcdfe_pkg::CountW'(1);
        end else if (protocol == lcdfe_pkg::ProtoExt) begin
          frame.bytes[0] = lcdfe_pkg::ByteEsc;
          frame.bytes[1] = lcdfe_pkg::CmdClear;
          frame.count    = lcdfe_pkg::CountW'(2);
        end else begin
          has_frame = 1'b0;
        end
      end
      lcdfe_pkg::OP_GOTO: begin
        frame.bytes[0] = lcdfe_pkg::ByteEsc;
        frame.bytes[1] = lcdfe_pkg::CmdGoto;
        frame.bytes[2] = column + 8'd1;
        frame.bytes[3] = row + 8'd1;
        frame.count    = lcdfe_pkg::CountW'(4);
      end
      lcdfe_pkg::OP_TEXT: begin
        frame.bytes[0] = text_byte;
        frame.count    = lcdfe_pkg::CountW'(1);
      end
      lcdfe_pkg::OP_DEFCHAR: begin
        frame.bytes[0] = lcdfe_pkg::ByteEsc;
        frame.bytes[1] = lcdfe_pkg::CmdDefChar;
        frame.bytes[2] = char_code;
        for (int i = 0; i < 8; i++) begin
          frame.bytes[3+i] = {3'd0, pattern[8*i +: 5]};
        end
        frame.count    = lcdfe_pkg::CountW'(lcdfe_pkg::FrameBytes);
      end
      lcdfe_pkg::OP_CONTRAST: begin
        frame.count = lcdfe_pkg::CountW'(1);
        if (is_query) begin
          frame.byte_valid = 1'b0;
          frame.level      = contrast_level;
        end else begin
          contrast_next  = clamped;
          frame.bytes[0] = lcdfe_pkg::ByteEsc;
          frame.bytes[1] = lcdfe_pkg::CmdContrast;
          frame.bytes[2] = clamped;
          frame.count    = lcdfe_pkg::CountW'(3);
          frame.level    = clamped;
        end
      end
      lcdfe_pkg::OP_BACKLIGHT: begin
        frame.count = lcdfe_pkg::CountW'(1);
        if (is_query) begin
          frame.byte_valid = 1'b0;
          frame.level      = backlight_level;
        end else begin
          backlight_next = clamped;
          frame.bytes[0] = lcdfe_pkg::ByteEsc;
          frame.level    = clamped;
          if (clamped == 8'd0) begin
            frame.bytes[1] = lcdfe_pkg::CmdBlOff;
            frame.count    = lcdfe_pkg::CountW'(2);
          end else begin
            frame.bytes[1] = lcdfe_pkg::CmdBlOn;
            frame.bytes[2] = clamped;
            frame.count    = lcdfe_pkg::CountW'(3);
          end
        end
      end
      lcdfe_pkg::OP_GPO: begin
        // default: answer-only, level 0
        frame.count      = lcdfe_pkg::CountW'(1);
        frame.byte_valid = 1'b0;
        if (protocol == lcdfe_pkg::ProtoBasic && gpo_index == 3'd0) begin
          frame.byte_valid = 1'b1;
          frame.bytes[0]   = lcdfe_pkg::ByteEsc;
          frame.count      = lcdfe_pkg::CountW'(2);
          if (!val_neg && !val_zero) begin
            frame.bytes[1] = lcdfe_pkg::CmdGpoOn;
            frame.level    = 8'd1;
          end else begin
            frame.bytes[1] = lcdfe_pkg::CmdGpoOff;
          end
        end else if (protocol == lcdfe_pkg::ProtoExt) begin
          frame.byte_valid = 1'b1;
          frame.bytes[0]   = lcdfe_pkg::ByteEsc;
          frame.bytes[2]   = gpo_num;
          frame.count      = lcdfe_pkg::CountW'(3);
          if (val_neg || val_zero) begin
            frame.bytes[1] = lcdfe_pkg::CmdGpoOff;
          end else if (clamped == lcdfe_pkg::LevelFull) begin
            frame.bytes[1] = lcdfe_pkg::CmdGpoOn;
            frame.level    = lcdfe_pkg::LevelFull;
          end else begin
            frame.bytes[1] = lcdfe_pkg::CmdGpoPwm;
            frame.bytes[3] = clamped;
            frame.count    = lcdfe_pkg::CountW'(4);
            frame.level    = clamped;
          end
        end
      end
      default: begin
        has_frame = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol        <= lcdfe_pkg::ProtoBasic;
      contrast_level  <= 8'd0;
      backlight_level <= 8'd0;
    end else begin
      if (cfg_we) begin
        protocol <= cfg_wdata;
      end
      if (accept) begin
        contrast_level  <= contrast_next;
        backlight_level <= backlight_next;
      end
    end
  end

endmodule

// File: rtl/lcdfe_queue.sv
// ----------------------------------------------------------------------------
// lcdfe_queue
// Two-entry frame queue between the front and the back.
// ----------------------------------------------------------------------------
module lcdfe_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdfe_pkg::frame_t  push_frame,
  input  logic               pop,
  output lcdfe_pkg::frame_t  head,
  output logic               empty,
  output logic               full
);

  lcdfe_pkg::frame_t                 entries [lcdfe_pkg::QueueDepth];
  logic [lcdfe_pkg::QPtrW-1:0]       wr_ptr;
  logic [lcdfe_pkg::QPtrW-1:0]       rd_ptr;
  logic [lcdfe_pkg::QCntW-1:0]       count;

  assign empty = (count == '0);
  assign full  = (count == lcdfe_pkg::QCntW'(lcdfe_pkg::QueueDepth));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= lcdfe_pkg::QCntW'(lcdfe_pkg::QueueDepth))
    else $error("queue count out of range");

endmodule

// File: rtl/lcdfe_back.sv
// ----------------------------------------------------------------------------
// lcdfe_back
// Shifts the queued frame out one byte per cycle, unless out_stall holds the output, into the output register.
// ----------------------------------------------------------------------------
module lcdfe_back (
  input  logic               clk,
  input  logic               rst,
  input  lcdfe_pkg::frame_t  head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [7:0]         level
);

  logic [lcdfe_pkg::CountW-1:0] idx;
  logic                         load;
  logic                         at_end;

  assign load   = (!out_valid || !out_stall) && !q_empty;
  assign at_end = (idx == head.count - 1'b1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= !q_empty;
      end
      if (load) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.bytes[idx];
      byte_valid <= head.byte_valid;
      last       <= at_end;
      level      <= head.level;
    end
  end

  a_idx_in_frame: assert property (@(posedge clk) disable iff (rst)
      !q_empty |-> idx < head.count)
    else $error("byte index past frame end");
  a_idx_idle: assert property (@(posedge clk) disable iff (rst) q_empty |-> idx == '0)
    else $error("byte index not reset between frames");
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
      load |=> out_valid)
    else $error("loaded byte not presented");

endmodule
